// ===== sv/spdb_pkg.sv =====
// Shared types, widths and constants of the sweep peak detector with bin blacklist.
// Used by every module of the block; depends on nothing else.
package spdb_pkg;

   localparam int MAX_BINS_DEFAULT = 128;

   localparam int FREQ_W  = 28;
   localparam int STEP_W  = 14;
   localparam int SHIFT_W = 2;
   localparam int LEVEL_W = 16;
   localparam int RSSI_W  = 9;
   localparam int BIN_OUT_W = 7;
   localparam int AGE_W   = 11;
   localparam int CMD_W   = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [FREQ_W-1:0]  START_FREQ_RESET    = 28'd43400000;
   localparam logic [STEP_W-1:0]  STEP_SIZE_RESET     = 14'd2500;
   localparam logic [SHIFT_W-1:0] STEPS_SHIFT_RESET   = 2'd1;
   localparam logic [LEVEL_W-1:0] TRIGGER_LEVEL_RESET = 16'd150;

   localparam logic [AGE_W-1:0]   AGE_LIMIT   = 11'd1024;
   localparam logic [LEVEL_W-1:0] LEVEL_AUTO  = 16'hFFFF;
   localparam logic [LEVEL_W-1:0] AUTO_MARGIN = 16'd8;
   localparam logic [LEVEL_W-1:0] MIN_NONE    = 16'hFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE         = 2'd0,
      CMD_BLOCK_PEAK     = 2'd1,
      CMD_RELAUNCH       = 2'd2,
      CMD_RELAUNCH_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_START_FREQ    = 2'd0,
      REG_STEP_SIZE     = 2'd1,
      REG_STEPS_SHIFT   = 2'd2,
      REG_TRIGGER_LEVEL = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  start_freq;
      logic [STEP_W-1:0]  step_size;
      logic [SHIFT_W-1:0] steps_shift;
      logic [LEVEL_W-1:0] trigger_level;
      logic               trig_load;
   } cfg_type;

   typedef struct packed {
      logic               measured;
      logic               sweep_done;
      logic [RSSI_W-1:0]  peak_level;
      logic               over_level;
      logic [LEVEL_W-1:0] min_level;
      logic [LEVEL_W-1:0] active_level;
   } status_type;

endpackage

// ===== sv/spdb_csr.sv =====
// Configuration register file of the sweep peak detector, APB-style write and read.
// Depends on spdb_pkg for widths, reset values and register indexes.
module spdb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spdb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spdb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spdb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output spdb_pkg::cfg_type                 cfg
);
   import spdb_pkg::*;

   logic [FREQ_W-1:0]  start_freq_ff,    start_freq_in;
   logic [STEP_W-1:0]  step_size_ff,     step_size_in;
   logic [SHIFT_W-1:0] steps_shift_ff,   steps_shift_in;
   logic [LEVEL_W-1:0] trigger_level_ff, trigger_level_in;
   logic               wr_en;
   reg_index_type      reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      start_freq_in    = start_freq_ff;
      step_size_in     = step_size_ff;
      steps_shift_in   = steps_shift_ff;
      trigger_level_in = trigger_level_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_START_FREQ:    start_freq_in    = csr_pwdata[FREQ_W-1:0];
            REG_STEP_SIZE:     step_size_in     = csr_pwdata[STEP_W-1:0];
            REG_STEPS_SHIFT:   steps_shift_in   = csr_pwdata[SHIFT_W-1:0];
            REG_TRIGGER_LEVEL: trigger_level_in = csr_pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_freq_ff    <= START_FREQ_RESET;
         step_size_ff     <= STEP_SIZE_RESET;
         steps_shift_ff   <= STEPS_SHIFT_RESET;
         trigger_level_ff <= TRIGGER_LEVEL_RESET;
      end else begin
         start_freq_ff    <= start_freq_in;
         step_size_ff     <= step_size_in;
         steps_shift_ff   <= steps_shift_in;
         trigger_level_ff <= trigger_level_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_FREQ:    csr_prdata = CSR_DATA_W'(start_freq_ff);
         REG_STEP_SIZE:     csr_prdata = CSR_DATA_W'(step_size_ff);
         REG_STEPS_SHIFT:   csr_prdata = CSR_DATA_W'(steps_shift_ff);
         REG_TRIGGER_LEVEL: csr_prdata = CSR_DATA_W'(trigger_level_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // The tracker reloads its live trigger in the same edge the register is written,
   // so the trigger level is handed on with the value being written.
   always_comb begin
      cfg.start_freq    = start_freq_ff;
      cfg.step_size     = step_size_ff;
      cfg.steps_shift   = steps_shift_ff;
      cfg.trigger_level = trigger_level_in;
      cfg.trig_load     = wr_en && (reg_idx == REG_TRIGGER_LEVEL);
   end

endmodule

// ===== sv/spdb_freq.sv =====
// Bin-to-frequency conversion: start frequency plus bin times step, modulo 2^28.
// Depends on spdb_pkg for field widths.
module spdb_freq #(
   parameter int MAX_BINS = spdb_pkg::MAX_BINS_DEFAULT
) (
   input  logic [spdb_pkg::FREQ_W-1:0]   start_freq,
   input  logic [spdb_pkg::STEP_W-1:0]   step_size,
   input  logic [$clog2(MAX_BINS)-1:0]   bin,
   output logic [spdb_pkg::FREQ_W-1:0]   freq
);
   import spdb_pkg::*;

   localparam int BIN_W  = $clog2(MAX_BINS);
   localparam int PROD_W = BIN_W + STEP_W;

   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(bin) * PROD_W'(step_size);
   assign freq = start_freq + FREQ_W'(prod);

endmodule

// ===== sv/spdb_track.sv =====
// Sweep state and per-word update: bin counter, sweep maximum, running minimum,
// held peak with aging, live trigger and the bin blacklist. Depends on spdb_pkg.
module spdb_track #(
   parameter int MAX_BINS = spdb_pkg::MAX_BINS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spdb_pkg::cfg_type                 cfg,
   input  logic                              step_en,
   input  spdb_pkg::cmd_type                 cmd,
   input  logic [spdb_pkg::RSSI_W-1:0]       rssi,
   output logic [$clog2(MAX_BINS)-1:0]       res_bin,
   output logic [$clog2(MAX_BINS)-1:0]       res_peak_bin,
   output spdb_pkg::status_type              status
);
   import spdb_pkg::*;

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   logic [MAX_BINS-1:0] blocked_ff,       blocked_in;
   logic [BIN_W-1:0]    current_bin_ff,   current_bin_in;
   logic [RSSI_W-1:0]   sweep_max_ff,     sweep_max_in;
   logic [BIN_W-1:0]    sweep_max_bin_ff, sweep_max_bin_in;
   logic [LEVEL_W-1:0]  running_min_ff,   running_min_in;
   logic [RSSI_W-1:0]   held_peak_ff,     held_peak_in;
   logic [BIN_W-1:0]    held_peak_bin_ff, held_peak_bin_in;
   logic [AGE_W-1:0]    peak_age_ff,      peak_age_in;
   logic                peak_set_ff,      peak_set_in;
   logic [LEVEL_W-1:0]  live_trigger_ff,  live_trigger_in;

   logic [CNT_W-1:0]    bin_count;
   logic [CNT_W-1:0]    bin_next;
   logic                last_bin;

   assign bin_count = CNT_W'(MAX_BINS) >> cfg.steps_shift;
   assign bin_next  = CNT_W'(current_bin_ff) + CNT_W'(1);
   // A bin at or past the end of a shortened sweep closes it as well.
   assign last_bin  = !(bin_next < bin_count);

   always_comb begin
      blocked_in       = blocked_ff;
      current_bin_in   = current_bin_ff;
      sweep_max_in     = sweep_max_ff;
      sweep_max_bin_in = sweep_max_bin_ff;
      running_min_in   = running_min_ff;
      held_peak_in     = held_peak_ff;
      held_peak_bin_in = held_peak_bin_ff;
      peak_age_in      = peak_age_ff;
      peak_set_in      = peak_set_ff;
      live_trigger_in  = live_trigger_ff;
      res_bin           = current_bin_ff;
      status.measured   = 1'b0;
      status.sweep_done = 1'b0;
      status.over_level = 1'b0;

      if (cfg.trig_load) begin
         live_trigger_in = cfg.trigger_level;
      end

      if (step_en) begin
         case (cmd)
            CMD_SAMPLE: begin
               if (!blocked_ff[current_bin_ff]) begin
                  status.measured = 1'b1;
                  if (rssi > sweep_max_ff) begin
                     sweep_max_in     = rssi;
                     sweep_max_bin_in = current_bin_ff;
                  end
                  if (LEVEL_W'(rssi) < running_min_ff) begin
                     running_min_in = LEVEL_W'(rssi);
                  end
               end
               if (!last_bin) begin
                  current_bin_in = BIN_W'(bin_next);
                  if (peak_age_ff < AGE_LIMIT) begin
                     peak_age_in = peak_age_ff + AGE_W'(1);
                  end
               end else begin
                  status.sweep_done = 1'b1;
                  if (!peak_set_ff || (peak_age_ff >= AGE_LIMIT) ||
                      (held_peak_ff < sweep_max_in)) begin
                     peak_age_in      = '0;
                     held_peak_in     = sweep_max_in;
                     held_peak_bin_in = sweep_max_bin_in;
                     peak_set_in      = 1'b1;
                     // The sweep maximum is at most 511, so the margin never saturates.
                     if (live_trigger_ff == LEVEL_AUTO) begin
                        live_trigger_in = LEVEL_W'(sweep_max_in) + AUTO_MARGIN;
                     end
                  end
                  status.over_level = (LEVEL_W'(held_peak_in) >= live_trigger_in);
                  current_bin_in   = '0;
                  sweep_max_in     = '0;
                  sweep_max_bin_in = '0;
               end
            end
            default: begin
               if (cmd == CMD_BLOCK_PEAK) begin
                  blocked_in[held_peak_bin_ff] = 1'b1;
               end
               held_peak_in     = '0;
               peak_age_in      = '0;
               current_bin_in   = '0;
               sweep_max_in     = '0;
               sweep_max_bin_in = '0;
               if (cmd inside {CMD_RELAUNCH, CMD_RELAUNCH_CLEAR}) begin
                  running_min_in  = MIN_NONE;
                  live_trigger_in = cfg.trigger_level;
               end
               if (cmd == CMD_RELAUNCH_CLEAR) begin
                  blocked_in = '0;
               end
               res_bin = '0;
            end
         endcase
      end

      res_peak_bin        = held_peak_bin_in;
      status.peak_level   = held_peak_in;
      status.min_level    = running_min_in;
      status.active_level = live_trigger_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff       <= '0;
         current_bin_ff   <= '0;
         sweep_max_ff     <= '0;
         sweep_max_bin_ff <= '0;
         running_min_ff   <= MIN_NONE;
         held_peak_ff     <= '0;
         held_peak_bin_ff <= '0;
         peak_age_ff      <= '0;
         peak_set_ff      <= 1'b0;
         live_trigger_ff  <= TRIGGER_LEVEL_RESET;
      end else begin
         blocked_ff       <= blocked_in;
         current_bin_ff   <= current_bin_in;
         sweep_max_ff     <= sweep_max_in;
         sweep_max_bin_ff <= sweep_max_bin_in;
         running_min_ff   <= running_min_in;
         held_peak_ff     <= held_peak_in;
         held_peak_bin_ff <= held_peak_bin_in;
         peak_age_ff      <= peak_age_in;
         peak_set_ff      <= peak_set_in;
         live_trigger_ff  <= live_trigger_in;
      end
   end

endmodule

// ===== sv/sweep_peak_detector_blacklist_core.sv =====
// Top level of the sweep peak detector with bin blacklist: stream ports, CSR port,
// result register. Depends on spdb_pkg, spdb_csr, spdb_track and spdb_freq.
//
// Usage:
//   The req_ stream carries one word per bin: req_tuser is the command (sample,
//   blacklist the held peak, relaunch, relaunch and clear the blacklist) and
//   req_tdata the signal strength. Every accepted word yields exactly one rsp_
//   word with the bin, its frequency, the held peak and the levels; rsp_tlast
//   marks the word that closed a sweep and rsp_tuser says the sample was used.
//   rsp_tvalid rises in the cycle after acceptance. Throughput is one word per
//   cycle while the receiver takes each word: the sweep state updates at every
//   accepted word and both bin-to-frequency multiplies sit in front of the
//   result register. When the receiver stalls, the result register holds its
//   word and req_tready stays low until the word is taken.
//   The csr_ port holds start frequency, step size, steps shift and trigger level
//   at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
//   Writing the trigger level also loads the live trigger.
//   Reset restores the register defaults, clears the blacklist and the peak, and
//   restarts the sweep at bin zero; no clearing pass is needed.
module sweep_peak_detector_blacklist_core #(
   parameter int MAX_BINS = spdb_pkg::MAX_BINS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: rssi[8:0]; tuser: cmd[1:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,
   input  logic [1:0]                        req_tuser,
   // tdata: bin_index[6:0], bin_freq[34:7], peak_bin[41:35], peak_freq[69:42],
   //        peak_level[78:70], over_level[79], min_level[95:80], active_level[111:96]
   // tuser: measured; tlast: sweep_done
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [111:0]                      rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spdb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spdb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spdb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import spdb_pkg::*;

   localparam int BIN_W = $clog2(MAX_BINS);

   cfg_type           cfg;
   status_type        status;
   logic              step_en;
   logic [BIN_W-1:0]  res_bin;
   logic [BIN_W-1:0]  res_peak_bin;
   logic [FREQ_W-1:0] bin_freq;
   logic [FREQ_W-1:0] peak_freq;
   logic [111:0]      tdata_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [111:0]      rsp_tdata_ff;
   logic              rsp_tuser_ff;
   logic              rsp_tlast_ff;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign step_en    = req_tvalid && req_tready;

   spdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spdb_track #(.MAX_BINS(MAX_BINS)) u_track (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step_en      (step_en),
      .cmd          (cmd_type'(req_tuser)),
      .rssi         (req_tdata[RSSI_W-1:0]),
      .res_bin      (res_bin),
      .res_peak_bin (res_peak_bin),
      .status       (status)
   );

   spdb_freq #(.MAX_BINS(MAX_BINS)) u_bin_freq (
      .start_freq (cfg.start_freq),
      .step_size  (cfg.step_size),
      .bin        (res_bin),
      .freq       (bin_freq)
   );

   spdb_freq #(.MAX_BINS(MAX_BINS)) u_peak_freq (
      .start_freq (cfg.start_freq),
      .step_size  (cfg.step_size),
      .bin        (res_peak_bin),
      .freq       (peak_freq)
   );

   assign tdata_in = {status.active_level, status.min_level, status.over_level,
                      status.peak_level, peak_freq, BIN_OUT_W'(res_peak_bin),
                      bin_freq, BIN_OUT_W'(res_bin)};

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (step_en) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_tdata_ff <= tdata_in;
         rsp_tuser_ff <= status.measured;
         rsp_tlast_ff <= status.sweep_done;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // A command word restarts the sweep and reports bin zero, unmeasured, not closing.
   a_cmd_restarts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != CMD_SAMPLE) |=>
         rsp_tvalid && (rsp_tdata[6:0] == 7'd0) && !rsp_tuser && !rsp_tlast)
      else $error("command word did not restart the sweep");

   a_over_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[79] |-> rsp_tlast)
      else $error("over-level reported outside sweep end");

   // A used sample always pulls the running minimum below the empty marker.
   a_measured_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[95:80] != MIN_NONE))
      else $error("measured sample left running minimum empty");

endmodule
